[hw/rtl/mtp_pkg.sv]
package mtp_pkg;

  localparam int RATE_W    = 19;
  localparam int TEMPO_W   = 18;
  localparam int BPB_SET_W = 8;
  localparam int BPP_SET_W = 9;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPB   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPP   = 2'd3;

  localparam logic [RATE_W-1:0]    RATE_RST  = 19'd48000;
  localparam logic [TEMPO_W-1:0]   TEMPO_RST = 18'd30720;
  localparam logic [BPB_SET_W-1:0] BPB_RST   = 8'd4;
  localparam logic [BPP_SET_W-1:0] BPP_RST   = 9'd4;

  // 60 s/min times Q8 tempo scale
  localparam int BEAT_DEN_K = 15360;
  localparam int BEAT_K_W   = 14;
  // widest divisor: beats per phrase times rate times 15360
  localparam int DIV_W      = 48;
  localparam int BPB_W      = 7;
  localparam int BPP_W      = 9;
  localparam int PBEATS_W   = 15;
  localparam int BPB_MAX    = 64;
  localparam int BPP_MAX    = 256;
  localparam int SIG_DEFAULT = 4;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] ST_MLO   = 5'd1;
  localparam logic [ST_W-1:0] ST_MHI   = 5'd2;
  localparam logic [ST_W-1:0] ST_MADD  = 5'd3;
  localparam logic [ST_W-1:0] ST_DBEAT = 5'd4;
  localparam logic [ST_W-1:0] ST_DBAR  = 5'd5;
  localparam logic [ST_W-1:0] ST_DPHR  = 5'd6;
  localparam logic [ST_W-1:0] ST_DBFR  = 5'd7;
  localparam logic [ST_W-1:0] ST_MBAR  = 5'd8;
  localparam logic [ST_W-1:0] ST_ABAR  = 5'd9;
  localparam logic [ST_W-1:0] ST_DBARF = 5'd10;
  localparam logic [ST_W-1:0] ST_MPHR  = 5'd11;
  localparam logic [ST_W-1:0] ST_APHR  = 5'd12;
  localparam logic [ST_W-1:0] ST_DPHRF = 5'd13;
  localparam logic [ST_W-1:0] ST_DSEC  = 5'd14;
  localparam logic [ST_W-1:0] ST_DSECF = 5'd15;
  localparam logic [ST_W-1:0] ST_DONE  = 5'd16;

  typedef struct packed {
    logic signed [15:0] frames;
    logic               restart;
  } item_t;

  typedef struct packed {
    logic [47:0] frame_position;
    logic [47:0] beat_count;
    logic [47:0] bar_count;
    logic [47:0] phrase_count;
    logic [5:0]  beat_within_bar;
    logic [13:0] beat_within_phrase;
    logic [15:0] beat_fraction;
    logic [15:0] bar_fraction;
    logic [15:0] phrase_fraction;
    logic [47:0] seconds_whole;
    logic [15:0] seconds_fraction;
  } result_t;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            take;
    logic            go;
    logic            load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic bypass;
    logic rate_zero;
  } sts_t;

endpackage

[hw/rtl/mtp_div.sv]
module mtp_div #(
  parameter int NW = 66,
  parameter int PB = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic                       frac,
  input  logic [mtp_pkg::DIV_W-1:0]  rem0,
  input  logic [NW-1:0]              dvd,
  input  logic [mtp_pkg::DIV_W-1:0]  dsr,
  output logic                       done,
  output logic [NW-1:0]              quo,
  output logic [mtp_pkg::DIV_W-1:0]  rem
);

  localparam int DW = mtp_pkg::DIV_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] dvd_sh;
  logic [DW-1:0] dsr_r;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          fit;

  always_comb begin
    sh   = {rem, dvd_sh[NW-1]};
    fit  = (sh >= {1'b0, dsr_r});
    diff = sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= frac ? CW'(PB) : CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem    <= rem0;
      quo    <= '0;
      dvd_sh <= dvd;
      dsr_r  <= dsr;
    end else if (busy) begin
      rem    <= fit ? diff[DW-1:0] : sh[DW-1:0];
      quo    <= {quo[NW-2:0], fit};
      dvd_sh <= {dvd_sh[NW-2:0], 1'b0};
    end
  end

endmodule

[hw/rtl/mtp_dp.sv]
module mtp_dp #(
  parameter int FRAME_BITS = 48,
  parameter int PHASE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtp_pkg::CFG_W-1:0]       cfg_data,
  input  mtp_pkg::item_t                  item,
  input  mtp_pkg::cmd_t                   cmd,
  output mtp_pkg::sts_t                   sts,
  output mtp_pkg::result_t                result
);

  localparam int DW   = mtp_pkg::DIV_W;
  localparam int NUMW = FRAME_BITS + mtp_pkg::TEMPO_W;
  localparam int NW   = (NUMW > 64) ? NUMW : 64;
  localparam int PW   = 32 + mtp_pkg::TEMPO_W;

  logic [mtp_pkg::RATE_W-1:0]    rate;
  logic [mtp_pkg::TEMPO_W-1:0]   tempo;
  logic [mtp_pkg::BPB_SET_W-1:0] bpb_set;
  logic [mtp_pkg::BPP_SET_W-1:0] bpp_set;

  logic [FRAME_BITS-1:0]         frame;
  logic [FRAME_BITS-1:0]         frame_base;
  logic [63:0]                   frame64;
  logic [PW-1:0]                 prod;
  logic [NUMW-1:0]               num;
  logic [DW-1:0]                 den;
  logic [63:0]                   beat;
  logic [DW-1:0]                 rem_b;
  logic [DW-1:0]                 t_num;
  logic [DW-1:0]                 t_den;
  logic [mtp_pkg::BPB_W-1:0]     bpb;
  logic [mtp_pkg::BPP_W-1:0]     bpp;
  logic [mtp_pkg::PBEATS_W-1:0]  pbeats;
  logic [47:0]                   bar;
  logic [47:0]                   phrase;
  logic [5:0]                    bib;
  logic [13:0]                   bip;
  logic [15:0]                   bfrac;
  logic [15:0]                   barf;
  logic [15:0]                   phrf;
  logic [47:0]                   secw;
  logic [15:0]                   secf;

  logic                          d_frac;
  logic [DW-1:0]                 d_rem0;
  logic [NW-1:0]                 d_dvd;
  logic [DW-1:0]                 d_dsr;
  logic                          d_done;
  logic [NW-1:0]                 d_quo;
  logic [DW-1:0]                 d_rem;

  function automatic logic [mtp_pkg::BPB_W-1:0] fit_bpb(
    input logic [mtp_pkg::BPB_SET_W-1:0] v
  );
    if (v == '0) begin
      return mtp_pkg::BPB_W'(mtp_pkg::SIG_DEFAULT);
    end else if (v > mtp_pkg::BPB_SET_W'(mtp_pkg::BPB_MAX)) begin
      return mtp_pkg::BPB_W'(mtp_pkg::BPB_MAX);
    end
    return mtp_pkg::BPB_W'(v);
  endfunction

  function automatic logic [mtp_pkg::BPP_W-1:0] fit_bpp(
    input logic [mtp_pkg::BPP_SET_W-1:0] v
  );
    if (v == '0) begin
      return mtp_pkg::BPP_W'(mtp_pkg::SIG_DEFAULT);
    end else if (v > mtp_pkg::BPP_SET_W'(mtp_pkg::BPP_MAX)) begin
      return mtp_pkg::BPP_W'(mtp_pkg::BPP_MAX);
    end
    return v;
  endfunction

  assign frame64        = 64'(frame);
  assign frame_base     = item.restart ? '0 : frame;
  assign sts.bypass     = (rate == '0) || (tempo == '0);
  assign sts.rate_zero  = (rate == '0);
  assign sts.div_done   = d_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate    <= mtp_pkg::RATE_RST;
      tempo   <= mtp_pkg::TEMPO_RST;
      bpb_set <= mtp_pkg::BPB_RST;
      bpp_set <= mtp_pkg::BPP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtp_pkg::REG_RATE:  rate    <= cfg_data[mtp_pkg::RATE_W-1:0];
        mtp_pkg::REG_TEMPO: tempo   <= cfg_data[mtp_pkg::TEMPO_W-1:0];
        mtp_pkg::REG_BPB:   bpb_set <= cfg_data[mtp_pkg::BPB_SET_W-1:0];
        mtp_pkg::REG_BPP:   bpp_set <= cfg_data[mtp_pkg::BPP_SET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (cmd.take) begin
      if (item.frames > 16'sd0) begin
        frame <= frame_base + FRAME_BITS'(unsigned'(item.frames));
      end else begin
        frame <= frame_base;
      end
    end
  end

  always_comb begin
    d_frac = 1'b0;
    d_rem0 = '0;
    d_dvd  = '0;
    d_dsr  = '0;
    unique case (cmd.op)
      mtp_pkg::ST_DBEAT: begin
        d_dvd = NW'(num);
        d_dsr = den;
      end
      mtp_pkg::ST_DBAR: begin
        d_dvd = NW'(beat);
        d_dsr = DW'(bpb);
      end
      mtp_pkg::ST_DPHR: begin
        d_dvd = NW'(beat);
        d_dsr = DW'(pbeats);
      end
      mtp_pkg::ST_DBFR: begin
        d_frac = 1'b1;
        d_rem0 = rem_b;
        d_dsr  = den;
      end
      mtp_pkg::ST_DBARF, mtp_pkg::ST_DPHRF: begin
        d_frac = 1'b1;
        d_rem0 = t_num;
        d_dsr  = t_den;
      end
      mtp_pkg::ST_DSEC: begin
        d_dvd = NW'(frame);
        d_dsr = DW'(rate);
      end
      mtp_pkg::ST_DSECF: begin
        d_frac = 1'b1;
        d_rem0 = t_num;
        d_dsr  = DW'(rate);
      end
      default: ;
    endcase
  end

  mtp_div #(
    .NW (NW),
    .PB (PHASE_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.go),
    .frac (d_frac),
    .rem0 (d_rem0),
    .dvd  (d_dvd),
    .dsr  (d_dsr),
    .done (d_done),
    .quo  (d_quo),
    .rem  (d_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      den <= DW'((mtp_pkg::BEAT_K_W + mtp_pkg::RATE_W)'(rate)
                 * (mtp_pkg::BEAT_K_W + mtp_pkg::RATE_W)'(mtp_pkg::BEAT_DEN_K));
      bpb <= fit_bpb(bpb_set);
      bpp <= fit_bpp(bpp_set);
    end
    unique case (cmd.op)
      mtp_pkg::ST_MLO: begin
        prod   <= PW'(frame64[31:0]) * PW'(tempo);
        pbeats <= mtp_pkg::PBEATS_W'(16'(bpb) * 16'(bpp));
      end
      mtp_pkg::ST_MHI: begin
        num  <= NUMW'(prod);
        prod <= PW'(frame64[63:32]) * PW'(tempo);
      end
      mtp_pkg::ST_MADD: begin
        num <= num + NUMW'({prod, 32'b0});
        if (sts.bypass) begin
          den   <= DW'(1);
          beat  <= frame64;
          rem_b <= '0;
        end
      end
      mtp_pkg::ST_MBAR: begin
        t_num <= DW'(bib) * den;
        t_den <= DW'(bpb) * den;
      end
      mtp_pkg::ST_MPHR: begin
        t_num <= DW'(bip) * den;
        t_den <= DW'(pbeats) * den;
      end
      mtp_pkg::ST_ABAR, mtp_pkg::ST_APHR: begin
        t_num <= t_num + rem_b;
      end
      mtp_pkg::ST_DSEC: begin
        if (sts.rate_zero) begin
          secw <= '0;
          secf <= '0;
        end
      end
      default: ;
    endcase
    if (d_done) begin
      unique case (cmd.op)
        mtp_pkg::ST_DBEAT: begin
          beat  <= d_quo[63:0];
          rem_b <= d_rem;
        end
        mtp_pkg::ST_DBAR: begin
          bar <= d_quo[47:0];
          bib <= d_rem[5:0];
        end
        mtp_pkg::ST_DPHR: begin
          phrase <= d_quo[47:0];
          bip    <= d_rem[13:0];
        end
        mtp_pkg::ST_DBFR:  bfrac <= 16'(d_quo[PHASE_BITS-1:0]);
        mtp_pkg::ST_DBARF: barf  <= 16'(d_quo[PHASE_BITS-1:0]);
        mtp_pkg::ST_DPHRF: phrf  <= 16'(d_quo[PHASE_BITS-1:0]);
        mtp_pkg::ST_DSEC: begin
          secw  <= d_quo[47:0];
          t_num <= d_rem;
        end
        mtp_pkg::ST_DSECF: secf <= 16'(d_quo[PHASE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.frame_position     <= 48'(frame);
      result.beat_count         <= beat[47:0];
      result.bar_count          <= bar;
      result.phrase_count       <= phrase;
      result.beat_within_bar    <= bib;
      result.beat_within_phrase <= bip;
      result.beat_fraction      <= bfrac;
      result.bar_fraction       <= barf;
      result.phrase_fraction    <= phrf;
      result.seconds_whole      <= secw;
      result.seconds_fraction   <= secf;
    end
  end

endmodule

[hw/rtl/mtp_ctrl.sv]
module mtp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  output logic           result_valid,
  input  logic           result_stall,
  input  mtp_pkg::sts_t  sts,
  output mtp_pkg::cmd_t  cmd
);

  logic [mtp_pkg::ST_W-1:0] state;
  logic [mtp_pkg::ST_W-1:0] state_next;
  logic                     started;
  logic                     is_div;
  logic                     sec_skip;

  always_comb begin
    case (state) inside
      mtp_pkg::ST_DBEAT, mtp_pkg::ST_DBAR, mtp_pkg::ST_DPHR, mtp_pkg::ST_DBFR,
      mtp_pkg::ST_DBARF, mtp_pkg::ST_DPHRF, mtp_pkg::ST_DSEC,
      mtp_pkg::ST_DSECF: is_div = 1'b1;
      default:           is_div = 1'b0;
    endcase
  end

  assign sec_skip   = (state == mtp_pkg::ST_DSEC) && sts.rate_zero;
  assign item_stall = (state != mtp_pkg::ST_IDLE);
  assign cmd.op     = state;
  assign cmd.take   = item_valid && (state == mtp_pkg::ST_IDLE);
  assign cmd.go     = is_div && !started && !sec_skip;
  assign cmd.load   = (state == mtp_pkg::ST_DONE) && (!result_valid || !result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      mtp_pkg::ST_IDLE:  if (cmd.take) state_next = mtp_pkg::ST_MLO;
      mtp_pkg::ST_MLO:   state_next = mtp_pkg::ST_MHI;
      mtp_pkg::ST_MHI:   state_next = mtp_pkg::ST_MADD;
      mtp_pkg::ST_MADD:  state_next = sts.bypass ? mtp_pkg::ST_DBAR : mtp_pkg::ST_DBEAT;
      mtp_pkg::ST_DBEAT: if (sts.div_done) state_next = mtp_pkg::ST_DBAR;
      mtp_pkg::ST_DBAR:  if (sts.div_done) state_next = mtp_pkg::ST_DPHR;
      mtp_pkg::ST_DPHR:  if (sts.div_done) state_next = mtp_pkg::ST_DBFR;
      mtp_pkg::ST_DBFR:  if (sts.div_done) state_next = mtp_pkg::ST_MBAR;
      mtp_pkg::ST_MBAR:  state_next = mtp_pkg::ST_ABAR;
      mtp_pkg::ST_ABAR:  state_next = mtp_pkg::ST_DBARF;
      mtp_pkg::ST_DBARF: if (sts.div_done) state_next = mtp_pkg::ST_MPHR;
      mtp_pkg::ST_MPHR:  state_next = mtp_pkg::ST_APHR;
      mtp_pkg::ST_APHR:  state_next = mtp_pkg::ST_DPHRF;
      mtp_pkg::ST_DPHRF: if (sts.div_done) state_next = mtp_pkg::ST_DSEC;
      mtp_pkg::ST_DSEC: begin
        if (sec_skip) begin
          state_next = mtp_pkg::ST_DONE;
        end else if (sts.div_done) begin
          state_next = mtp_pkg::ST_DSECF;
        end
      end
      mtp_pkg::ST_DSECF: if (sts.div_done) state_next = mtp_pkg::ST_DONE;
      mtp_pkg::ST_DONE:  if (cmd.load) state_next = mtp_pkg::ST_IDLE;
      default:           state_next = mtp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mtp_pkg::ST_IDLE;
      started      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (sts.div_done) begin
        started <= 1'b0;
      end else if (cmd.go) begin
        started <= 1'b1;
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/musical_transport_position_top.sv]
// Musical transport position counter.
// Item channel (item_valid/item_stall/item): each transaction adds frames
// (when positive) to the frame counter, after clearing it when restart is set.
// Result channel (result_valid/result_stall/result): one transaction per item
// with frame, beat, bar and phrase position, phases and elapsed seconds.
// Config port: cfg_we writes cfg_data into register cfg_index (0 rate,
// 1 tempo Q8, 2 beats per bar, 3 bars per phrase); write only while idle.
// Eight long divisions run one bit per cycle on a single shared restoring
// divider. Zero tempo skips the beat division; zero rate skips it and both
// seconds divisions.
// One item is in work at a time; the next is taken as soon as the previous
// result sits in the output register, even while it is still stalled.
// A result stalled by result_stall holds; the finished item then waits in the
// controller until the output register frees.
// Reset: counter cleared, registers back to 48000 Hz, 120 BPM, 4/4, 4 bars.
module musical_transport_position_top #(
  parameter int FRAME_BITS = 48,
  parameter int PHASE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  mtp_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output mtp_pkg::result_t                result
);

  mtp_pkg::cmd_t cmd;
  mtp_pkg::sts_t sts;

  mtp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mtp_dp #(
    .FRAME_BITS (FRAME_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("block idle right after taking a transaction");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.op == mtp_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_no_go_on_done: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> !cmd.go)
    else $error("divider restarted while finishing");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!result_valid || !result_stall))
    else $error("output register overwritten while stalled");

endmodule

[tb/musical_transport_position_top_test.sv]
module musical_transport_position_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int SETTLE = 450;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int NUM_PHASES = 8;

  class position_scoreboard;
    logic [127:0] rate, tempo, bpb_set, bpp_set;
    logic [47:0] frame_ctr;
    result_t expected_q[$];
    int fails, checked;

    function void reset_state();
      rate = RATE_RST; tempo = TEMPO_RST; bpb_set = BPB_RST; bpp_set = BPP_RST;
      frame_ctr = '0; fails = 0; checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_RATE:  rate = val[RATE_W-1:0];
        REG_TEMPO: tempo = val[TEMPO_W-1:0];
        REG_BPB:   bpb_set = val[BPB_SET_W-1:0];
        REG_BPP:   bpp_set = val[BPP_SET_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [127:0] fit(logic [127:0] v, logic [127:0] hi);
      if (v == 0) return SIG_DEFAULT;
      return (v > hi) ? hi : v;
    endfunction

    function logic [127:0] phase_q16(logic [127:0] num, logic [127:0] den);
      if (den == 0 || num >= den) return '0;
      return (num << 16) / den;
    endfunction

    function void note_item(item_t it);
      logic [127:0] f, num, den, beat, rem, bpb, pb, bib, bip;
      result_t r;
      if (it.restart) frame_ctr = '0;
      if (it.frames > 0) frame_ctr = frame_ctr + {32'd0, it.frames[15:0]};
      f = frame_ctr;
      if (rate != 0 && tempo != 0) begin
        num = f * tempo;
        den = rate * BEAT_DEN_K;
        beat = num / den;
        rem = num % den;
      end else begin
        den = 1;
        beat = f;
        rem = 0;
      end
      beat = {64'd0, beat[63:0]};
      bpb = fit(bpb_set, BPB_MAX);
      pb = bpb * fit(bpp_set, BPP_MAX);
      bib = beat % bpb;
      bip = beat % pb;
      r.frame_position = f[47:0];
      r.beat_count = beat[47:0];
      r.bar_count = 48'(beat / bpb);
      r.phrase_count = 48'(beat / pb);
      r.beat_within_bar = bib[5:0];
      r.beat_within_phrase = bip[13:0];
      r.beat_fraction = 16'(phase_q16(rem, den));
      r.bar_fraction = 16'(phase_q16(bib * den + rem, bpb * den));
      r.phrase_fraction = 16'(phase_q16(bip * den + rem, pb * den));
      if (rate != 0) begin
        r.seconds_whole = 48'(f / rate);
        r.seconds_fraction = 16'(phase_q16(f % rate, rate));
      end else begin
        r.seconds_whole = '0;
        r.seconds_fraction = '0;
      end
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        fails++;
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
      end
    endfunction

    function void check(result_t a);
      result_t e;
      if (expected_q.size() == 0) begin
        fails++;
        $display("%0t unexpected result transaction: expected none actual %p", $realtime, a);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("frame_position", e.frame_position, a.frame_position);
      cmp("beat_count", e.beat_count, a.beat_count);
      cmp("bar_count", e.bar_count, a.bar_count);
      cmp("phrase_count", e.phrase_count, a.phrase_count);
      cmp("beat_within_bar", e.beat_within_bar, a.beat_within_bar);
      cmp("beat_within_phrase", e.beat_within_phrase, a.beat_within_phrase);
      cmp("beat_fraction", e.beat_fraction, a.beat_fraction);
      cmp("bar_fraction", e.bar_fraction, a.bar_fraction);
      cmp("phrase_fraction", e.phrase_fraction, a.phrase_fraction);
      cmp("seconds_whole", e.seconds_whole, a.seconds_whole);
      cmp("seconds_fraction", e.seconds_fraction, a.seconds_fraction);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  position_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  musical_transport_position_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < rx_stall_pct);
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.reset_state();
    forever begin
      @(negedge clk);
      if (!rst && result_valid && !result_stall) sb.check(result);
    end
  end

  task automatic send_frames(logic signed [15:0] frames, logic restart);
    item_t it;
    logic acc;
    it.frames = frames;
    it.restart = restart;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      item <= item_t'($urandom);
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do begin
      @(negedge clk);
      acc = !item_stall;
      @(posedge clk);
    end while (!acc);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] t,
                           logic [CFG_W-1:0] b, logic [CFG_W-1:0] p);
    drain();
    write_reg(REG_RATE, r);
    write_reg(REG_TEMPO, t);
    write_reg(REG_BPB, b);
    write_reg(REG_BPP, p);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_stall_pct = 80;
    send_frames(16'sd0, 1'b0);
    send_frames(16'sd1, 1'b0);
    send_frames(16'sd32767, 1'b0);
    send_frames(-16'sd1, 1'b0);
    send_frames(-16'sd32768, 1'b0);
    send_frames(16'sd12000, 1'b0);
    send_frames(16'sd0, 1'b1);
    send_frames(16'sd32767, 1'b0);
    send_frames(-16'sd5, 1'b1);
    send_frames(16'sd1, 1'b1);
    send_frames(16'sd24000, 1'b0);
    send_frames(16'sd32767, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(44100, 35840, 3, 0);
        1: configure(384000, 256000, 64, 256);
        2: configure(1, 1, 1, 1);
        3: configure(0, 30720, 255, 511);
        4: configure(48000, 0, 0, 1);
        5: configure('1, '1, '1, '1);
        6: configure(0, 0, 0, 0);
        default: configure($urandom_range(384000), $urandom_range(256000),
                           $urandom_range(70), $urandom_range(300));
      endcase
      if (ph < 3) begin
        tx_idle_pct = 17; rx_stall_pct = 80;
      end else if (ph < 6) begin
        tx_idle_pct = 80; rx_stall_pct = 17;
      end else begin
        tx_idle_pct = 0; rx_stall_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_frames(16'($urandom), $urandom_range(9) == 0);
    end

    drain();
    $display("Ran %0d item transactions over %0d register settings, %0d results checked,",
             items_sent, NUM_PHASES + 1, sb.checked);
    $display("covering zero rate and tempo, clamped signatures and both stall patterns.");
    if (sb.fails == 0 && sb.expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
